### hdl/pcf_pkg.sv
`default_nettype none

package pcf_pkg;

    localparam int unsigned ChanW = 8;

    localparam logic [ChanW-1:0] CHAN_MAX     = 8'd255;
    localparam logic [ChanW-1:0] OPAQUE_LIMIT = 8'd245;
    localparam logic [ChanW-1:0] BRIGHT_STEP  = 8'd50;

    // 1/3 as 683 / 2048, exact for sums up to 765
    localparam logic [10:0] THIRD_Q11 = 11'd683;

    // filter mode codes
    localparam logic [3:0] MODE_GRAY     = 4'd1;
    localparam logic [3:0] MODE_NEGATIVE = 4'd2;
    localparam logic [3:0] MODE_SEPIA    = 4'd3;
    localparam logic [3:0] MODE_BRIGHT   = 4'd5;
    localparam logic [3:0] MODE_OPACITY  = 4'd6;
    localparam logic [3:0] MODE_RED      = 4'd7;
    localparam logic [3:0] MODE_GREEN    = 4'd8;
    localparam logic [3:0] MODE_BLUE     = 4'd9;

    // register indexes
    localparam logic REG_FILTER_MODE = 1'b0;

    typedef struct packed {
        logic [ChanW-1:0] alpha_in;
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [ChanW-1:0] alpha_out;
        logic [ChanW-1:0] red_out;
        logic [ChanW-1:0] green_out;
        logic [ChanW-1:0] blue_out;
    } t_pixel_out;

    // one sepia output channel, Q10 coefficients, truncated then saturated
    function automatic logic [ChanW-1:0] sepia_chan(
        input logic [9:0]       cr,
        input logic [9:0]       cg,
        input logic [9:0]       cb,
        input logic [ChanW-1:0] r,
        input logic [ChanW-1:0] g,
        input logic [ChanW-1:0] b
    );
        logic [18:0] acc;
        logic [8:0]  q;
        acc = 19'(r * cr) + 19'(g * cg) + 19'(b * cb);
        q   = acc[18:10];
        return q[8] ? CHAN_MAX : q[ChanW-1:0];
    endfunction

    function automatic logic [ChanW-1:0] sat_add(
        input logic [ChanW-1:0] c,
        input logic [ChanW-1:0] step
    );
        logic [ChanW:0] s;
        s = {1'b0, c} + {1'b0, step};
        return s[ChanW] ? CHAN_MAX : s[ChanW-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/per_pixel_color_filter.sv
`default_nettype none

// Per-pixel ARGB color filter. One pixel beat per clock in and out while
// i_ready stays high; a pixel is registered at the input, filtered by the
// mode in register filter_mode (byte address 0), and registered again at the
// output, where o_valid rises and the beat waits until i_ready takes it.
// The two-register pipeline holds up to two pixels, so one more input beat is
// taken while a result waits on i_ready. Modes: 1 gray, 2 negative, 3 sepia,
// 5 brightness, 6 opacity, 7/8/9 red/green/blue only; all other values pass
// the pixel. Change filter_mode only while no pixel is in flight.
module per_pixel_color_filter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pcf_pkg::t_pixel_in  i_pixel,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pcf_pkg::t_pixel_out      o_pixel,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    logic [3:0]          filter_mode;
    logic                r_in_valid, n_in_valid;
    logic                r_out_valid, n_out_valid;
    pcf_pkg::t_pixel_in  r_in;
    pcf_pkg::t_pixel_out r_out;
    pcf_pkg::t_pixel_out filt;
    logic                advance;
    logic                in_take;

    pcf_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_filter_mode (filter_mode)
    );

    pcf_filter u_filter (
        .i_mode (filter_mode),
        .i_pix  (r_in),
        .o_pix  (filt)
    );

    // output stage frees up when empty or its beat is taken
    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_in_valid;
        end
        if (o_ready) begin
            n_in_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_pixel;
        end
        if (advance && r_in_valid) begin
            r_out <= filt;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid)
        else $error("input stalled while pipeline has room");

    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted pixel lost at input stage");

    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance |=> r_out_valid)
        else $error("pixel lost between stages");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |=> r_in_valid && r_out_valid)
        else $error("stalled pipeline dropped a pixel");
`endif

endmodule

`default_nettype wire

### hdl/pcf_apb_regs.sv
`default_nettype none

module pcf_apb_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [3:0]  o_filter_mode
);

    logic [3:0] r_filter_mode;
    logic [3:0] n_filter_mode;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == pcf_pkg::REG_FILTER_MODE);

    always_comb begin
        n_filter_mode = r_filter_mode;
        if (wr_en) begin
            n_filter_mode = pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= 4'd0;
        end else begin
            r_filter_mode <= n_filter_mode;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == pcf_pkg::REG_FILTER_MODE) begin
            prdata = {28'd0, r_filter_mode};
        end
    end

    assign o_filter_mode = r_filter_mode;

endmodule

`default_nettype wire

### hdl/pcf_filter.sv
`default_nettype none

module pcf_filter (
    input  wire logic [3:0]          i_mode,
    input  wire pcf_pkg::t_pixel_in  i_pix,
    output pcf_pkg::t_pixel_out      o_pix
);

    logic [7:0]  r, g, b, a;
    logic [9:0]  sum;
    logic [20:0] sum_scaled;
    logic [7:0]  mean;
    logic        all_bright;

    assign a = i_pix.alpha_in;
    assign r = i_pix.red_in;
    assign g = i_pix.green_in;
    assign b = i_pix.blue_in;

    assign sum        = 10'(r) + 10'(g) + 10'(b);
    assign sum_scaled = 21'(sum * pcf_pkg::THIRD_Q11);
    assign mean       = sum_scaled[18:11];

    assign all_bright = (r > pcf_pkg::OPAQUE_LIMIT) && (g > pcf_pkg::OPAQUE_LIMIT)
                     && (b > pcf_pkg::OPAQUE_LIMIT);

    always_comb begin
        o_pix.alpha_out = a;
        o_pix.red_out   = r;
        o_pix.green_out = g;
        o_pix.blue_out  = b;
        case (i_mode)
            pcf_pkg::MODE_GRAY: begin
                o_pix.red_out   = mean;
                o_pix.green_out = mean;
                o_pix.blue_out  = mean;
            end
            pcf_pkg::MODE_NEGATIVE: begin
                o_pix.red_out   = pcf_pkg::CHAN_MAX - r;
                o_pix.green_out = pcf_pkg::CHAN_MAX - g;
                o_pix.blue_out  = pcf_pkg::CHAN_MAX - b;
            end
            pcf_pkg::MODE_SEPIA: begin
                o_pix.red_out   = pcf_pkg::sepia_chan(10'd402, 10'd787, 10'd194, r, g, b);
                o_pix.green_out = pcf_pkg::sepia_chan(10'd357, 10'd702, 10'd172, r, g, b);
                o_pix.blue_out  = pcf_pkg::sepia_chan(10'd279, 10'd547, 10'd134, r, g, b);
            end
            pcf_pkg::MODE_BRIGHT: begin
                o_pix.red_out   = pcf_pkg::sat_add(r, pcf_pkg::BRIGHT_STEP);
                o_pix.green_out = pcf_pkg::sat_add(g, pcf_pkg::BRIGHT_STEP);
                o_pix.blue_out  = pcf_pkg::sat_add(b, pcf_pkg::BRIGHT_STEP);
            end
            pcf_pkg::MODE_OPACITY: begin
                if (all_bright) begin
                    o_pix.alpha_out = 8'd0;
                end
            end
            pcf_pkg::MODE_RED: begin
                o_pix.green_out = 8'd0;
                o_pix.blue_out  = 8'd0;
            end
            pcf_pkg::MODE_GREEN: begin
                o_pix.red_out  = 8'd0;
                o_pix.blue_out = 8'd0;
            end
            pcf_pkg::MODE_BLUE: begin
                o_pix.red_out   = 8'd0;
                o_pix.green_out = 8'd0;
            end
            default: begin
                o_pix.alpha_out = a;
            end
        endcase
    end

endmodule

`default_nettype wire

### verif/per_pixel_color_filter_test.sv
`timescale 1ns / 1ps

module per_pixel_color_filter_test;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // modes that have no name in the package
    localparam logic [3:0] MODE_THROUGH  = 4'd0;
    localparam logic [3:0] MODE_BLUR     = 4'd4;
    localparam logic [3:0] MODE_SPARE_LO = 4'd10;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    localparam logic [2:0] ADDR_FILTER_MODE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED      = 3'd4;

    // sepia matrix in Q10
    localparam int unsigned SEPIA_RR = 402, SEPIA_RG = 787, SEPIA_RB = 194;
    localparam int unsigned SEPIA_GR = 357, SEPIA_GG = 702, SEPIA_GB = 172;
    localparam int unsigned SEPIA_BR = 279, SEPIA_BG = 547, SEPIA_BB = 134;

    typedef struct {
        logic [3:0]          mode;
        pcf_pkg::t_pixel_in  px;
        bit                  given;
        pcf_pkg::t_pixel_out want;
    } t_pixel_row;

    localparam int NUM_ROWS = 27;

    t_pixel_row pixel_rows [NUM_ROWS] = '{
        '{MODE_THROUGH,            32'h00000000, 1'b1, 32'h00000000},
        '{MODE_THROUGH,            32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{MODE_THROUGH,            32'hA55AC33C, 1'b1, 32'hA55AC33C},
        '{pcf_pkg::MODE_GRAY,      32'h80FFFFFF, 1'b1, 32'h80FFFFFF},
        '{pcf_pkg::MODE_GRAY,      32'h7F000102, 1'b1, 32'h7F010101},
        '{pcf_pkg::MODE_GRAY,      32'h01010100, 1'b1, 32'h01000000},
        '{pcf_pkg::MODE_GRAY,      32'h12345678, 1'b0, 32'h00000000},
        '{pcf_pkg::MODE_NEGATIVE,  32'h00000000, 1'b1, 32'h00FFFFFF},
        '{pcf_pkg::MODE_NEGATIVE,  32'hFFFFFFFF, 1'b1, 32'hFF000000},
        '{pcf_pkg::MODE_NEGATIVE,  32'h3C0F7AE1, 1'b0, 32'h00000000},
        '{pcf_pkg::MODE_SEPIA,     32'hFFFFFFFF, 1'b1, 32'hFFFFFFEF},
        '{pcf_pkg::MODE_SEPIA,     32'h00000000, 1'b1, 32'h00000000},
        '{pcf_pkg::MODE_SEPIA,     32'h80402010, 1'b0, 32'h00000000},
        '{pcf_pkg::MODE_SEPIA,     32'h00FF0000, 1'b0, 32'h00000000},
        // red and green saturate, blue does not
        '{pcf_pkg::MODE_SEPIA,     32'h44FFFF00, 1'b0, 32'h00000000},
        '{MODE_BLUR,               32'h5A6B7C8D, 1'b1, 32'h5A6B7C8D},
        '{pcf_pkg::MODE_BRIGHT,    32'h00000000, 1'b1, 32'h00323232},
        '{pcf_pkg::MODE_BRIGHT,    32'h11CDCECC, 1'b1, 32'h11FFFFFE},
        '{pcf_pkg::MODE_BRIGHT,    32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{pcf_pkg::MODE_OPACITY,   32'hFFF6F6F6, 1'b1, 32'h00F6F6F6},
        '{pcf_pkg::MODE_OPACITY,   32'hFFF5F6F6, 1'b1, 32'hFFF5F6F6},
        '{pcf_pkg::MODE_OPACITY,   32'h80F6F6F5, 1'b1, 32'h80F6F6F5},
        '{pcf_pkg::MODE_RED,       32'h12345678, 1'b1, 32'h12340000},
        '{pcf_pkg::MODE_GREEN,     32'h12345678, 1'b1, 32'h12005600},
        '{pcf_pkg::MODE_BLUE,      32'h12345678, 1'b1, 32'h12000078},
        '{MODE_SPARE_LO,           32'hDEADBEEF, 1'b1, 32'hDEADBEEF},
        '{MODE_SPARE_HI,           32'h0F0F0F0F, 1'b1, 32'h0F0F0F0F}
    };

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    pcf_pkg::t_pixel_in  i_pixel = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    pcf_pkg::t_pixel_out o_pixel;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // typed-in expectation that travels with the pixel beat
    bit                  pin_given = 1'b0;
    pcf_pkg::t_pixel_out pin_want  = '0;

    logic [3:0]          mode_shadow = MODE_THROUGH;
    pcf_pkg::t_pixel_out pending_pixels [$];
    int unsigned         mismatches  = 0;
    int unsigned         cycle_count = 0;
    int                  burst_left  = 0;
    logic [15:0]         sink_tick   = '0;

    per_pixel_color_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_pixel),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clamp_chan(input int unsigned v);
        return (v > pcf_pkg::CHAN_MAX) ? pcf_pkg::CHAN_MAX : v[7:0];
    endfunction

    function automatic logic [7:0] sepia_channel(input int unsigned kr, input int unsigned kg,
                                                 input int unsigned kb,
                                                 input pcf_pkg::t_pixel_in px);
        return clamp_chan((kr * px.red_in + kg * px.green_in + kb * px.blue_in) >> 10);
    endfunction

    function automatic pcf_pkg::t_pixel_out filtered_pixel(input pcf_pkg::t_pixel_in px,
                                                           input logic [3:0] mode);
        pcf_pkg::t_pixel_out res;
        int unsigned         mean;
        res = px;
        case (mode)
            pcf_pkg::MODE_GRAY: begin
                mean = (px.red_in + px.green_in + px.blue_in) / 3;
                res.red_out   = mean[7:0];
                res.green_out = mean[7:0];
                res.blue_out  = mean[7:0];
            end
            pcf_pkg::MODE_NEGATIVE: begin
                res.red_out   = pcf_pkg::CHAN_MAX - px.red_in;
                res.green_out = pcf_pkg::CHAN_MAX - px.green_in;
                res.blue_out  = pcf_pkg::CHAN_MAX - px.blue_in;
            end
            pcf_pkg::MODE_SEPIA: begin
                res.red_out   = sepia_channel(SEPIA_RR, SEPIA_RG, SEPIA_RB, px);
                res.green_out = sepia_channel(SEPIA_GR, SEPIA_GG, SEPIA_GB, px);
                res.blue_out  = sepia_channel(SEPIA_BR, SEPIA_BG, SEPIA_BB, px);
            end
            pcf_pkg::MODE_BRIGHT: begin
                res.red_out   = clamp_chan(px.red_in + pcf_pkg::BRIGHT_STEP);
                res.green_out = clamp_chan(px.green_in + pcf_pkg::BRIGHT_STEP);
                res.blue_out  = clamp_chan(px.blue_in + pcf_pkg::BRIGHT_STEP);
            end
            pcf_pkg::MODE_OPACITY: begin
                if (px.red_in > pcf_pkg::OPAQUE_LIMIT && px.green_in > pcf_pkg::OPAQUE_LIMIT &&
                    px.blue_in > pcf_pkg::OPAQUE_LIMIT)
                    res.alpha_out = '0;
            end
            pcf_pkg::MODE_RED: begin
                res.green_out = '0;
                res.blue_out  = '0;
            end
            pcf_pkg::MODE_GREEN: begin
                res.red_out  = '0;
                res.blue_out = '0;
            end
            pcf_pkg::MODE_BLUE: begin
                res.red_out   = '0;
                res.green_out = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // bias toward the thresholds of opacity and brightness and the rails
    function automatic logic [7:0] random_chan();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(240, 255));
            1:       return $urandom_range(0, 1) ? pcf_pkg::CHAN_MAX : 8'd0;
            2:       return 8'($urandom_range(195, 215));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input pcf_pkg::t_pixel_in px, input bit given,
                              input pcf_pkg::t_pixel_out want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_pixel   <= px;
        pin_given <= given;
        pin_want  <= want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [3:0] value);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[31:4], value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mode_readback();
        // bus idles between transfers
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_FILTER_MODE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {28'd0, mode_shadow}) begin
            mismatches++;
            $display("%0t: filter_mode readback expected %h got %h",
                     $time, {28'd0, mode_shadow}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mode(input logic [3:0] mode);
        drain_results();
        apb_write(ADDR_FILTER_MODE, mode);
        check_mode_readback();
    endtask

    // shadow of filter_mode and the store of expected pixels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            pending_pixels.push_back(pin_given ? pin_want : filtered_pixel(i_pixel, mode_shadow));
        if (!i_rst_n)
            mode_shadow <= MODE_THROUGH;
        else if (psel && penable && pwrite && pready && paddr == ADDR_FILTER_MODE)
            mode_shadow <= pwdata[3:0];
    end

    always @(posedge i_clk) begin
        string               names [4];
        pcf_pkg::t_pixel_out want;
        names = '{"blue", "green", "red", "alpha"};
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel beat %h", $time, o_pixel);
            end else begin
                want = pending_pixels.pop_front();
                for (int k = 3; k >= 0; k--) begin
                    if (o_pixel[k*8 +: 8] !== want[k*8 +: 8]) begin
                        mismatches++;
                        $display("%0t: %s channel expected %h got %h",
                                 $time, names[k], want[k*8 +: 8], o_pixel[k*8 +: 8]);
                    end
                end
            end
        end
    end

    // sink stall pattern changes with bits 9:8 of sink_tick
    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 16'd1;
        case (sink_tick[9:8])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= 1'($urandom_range(0, 1));
            2'd2:    i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (sink_tick[1:0] != 2'd3);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL per_pixel_color_filter");
            $finish;
        end
    end

    initial begin
        logic [3:0]         cur_mode;
        pcf_pkg::t_pixel_in px;
        cur_mode = MODE_THROUGH;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < NUM_ROWS; n++) begin
            if (pixel_rows[n].mode != cur_mode) begin
                cur_mode = pixel_rows[n].mode;
                set_mode(cur_mode);
            end
            push_pixel(pixel_rows[n].px, pixel_rows[n].given, pixel_rows[n].want);
        end

        // a write to an address past the register must not change the mode
        drain_results();
        apb_write(ADDR_UNUSED, pcf_pkg::MODE_NEGATIVE);
        check_mode_readback();
        push_pixel(32'h01020304, 1'b1, 32'h01020304);

        for (int phase = 0; phase < 17; phase++) begin
            set_mode(phase < 16 ? 4'(phase) : 4'($urandom_range(0, 15)));
            for (int n = 0; n < 100; n++) begin
                px.alpha_in = ($urandom_range(0, 3) == 0) ? random_chan() : 8'($urandom());
                px.red_in   = random_chan();
                px.green_in = random_chan();
                px.blue_in  = random_chan();
                push_pixel(px, 1'b0, '0);
            end
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS per_pixel_color_filter");
        else
            $display("FAIL per_pixel_color_filter");
        $finish;
    end

endmodule

### filelist.f
hdl/pcf_pkg.sv
hdl/pcf_apb_regs.sv
hdl/pcf_filter.sv
hdl/per_pixel_color_filter.sv
verif/per_pixel_color_filter_test.sv
